>>> design/hact_pkg.sv
// Shared types, constants and codes for the hit address count table.
`default_nettype none

package hact_pkg;

   // Defaults for the top-level parameters.
   localparam int DEPTH_DEFAULT  = 1024;
   localparam int ADDR_W_DEFAULT = 64;

   // Fixed field widths of the request and response words.
   localparam int ADDR_PORT_W = 64;
   localparam int IDX_PORT_W  = 10;
   localparam int COUNT_W     = 32;
   localparam int USED_W      = 11;

   // Width that holds any index or fill count over the whole depth range.
   localparam int WIDE_W = 17;

   typedef enum logic [1:0] {
      CMD_RECORD = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      RES_NEW        = 3'd0,
      RES_INCREMENT  = 3'd1,
      RES_DROPPED    = 3'd2,
      RES_IGNORED    = 3'd3,
      RES_READ_VALID = 3'd4,
      RES_READ_EMPTY = 3'd5,
      RES_CLEARED    = 3'd6
   } res_code_type;

   // Where the pending result takes its entry fields from.
   typedef enum logic [2:0] {
      SRC_ZERO,
      SRC_INDEX,
      SRC_STORED,
      SRC_BUMPED,
      SRC_NEW
   } res_src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SEARCH,
      ST_READ_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [ADDR_PORT_W-1:0]   hit_address;
      logic                     debug_status;
      logic [IDX_PORT_W-1:0]    read_index;
   } req_word_type;

   typedef struct packed {
      res_code_type             result_code;
      logic [IDX_PORT_W-1:0]    entry_index;
      logic [ADDR_PORT_W-1:0]   entry_address;
      logic [COUNT_W-1:0]       entry_count;
      logic                     overflow_flag;
      logic [COUNT_W-1:0]       total_hits;
      logic [USED_W-1:0]        entries_used;
   } rsp_word_type;

   // Controller to datapath.
   typedef struct packed {
      logic          req_load;
      logic          clear;
      logic          hit_bump;
      logic          scan_start;
      logic          rd_scan;
      logic          rd_index;
      logic          wr_new;
      logic          wr_bump;
      logic          set_ovf;
      logic          res_load;
      res_code_type  res_code;
      res_src_type   res_src;
      logic          emit;
   } ctl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      cmd_type  cmd;
      logic     debug_status;
      logic     in_range;
      logic     more;
      logic     rd_pending;
      logic     hit;
      logic     full;
      logic     rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> design/hact_ctrl.sv
// Sequencer for record, read and clear commands of the hit address count table.
`default_nettype none

module hact_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire hact_pkg::dp_status_type status,
   output hact_pkg::ctl_cmd_type      cmd
);
   import hact_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (status.cmd)
               CMD_RECORD: begin
                  state_in = status.debug_status ? ST_SEARCH : ST_EMIT;
               end
               CMD_READ: begin
                  state_in = status.in_range ? ST_READ_WAIT : ST_EMIT;
               end
               default: begin
                  state_in = ST_EMIT;
               end
            endcase
         end
         ST_SEARCH: begin
            if (status.hit || !(status.more || status.rd_pending)) state_in = ST_EMIT;
         end
         ST_READ_WAIT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      cmd.res_code = RES_IGNORED;
      cmd.res_src = SRC_ZERO;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.req_load = req_valid;
         end
         ST_DISPATCH: begin
            case (status.cmd)
               CMD_RECORD: begin
                  if (status.debug_status) begin
                     cmd.hit_bump = 1'b1;
                     cmd.scan_start = 1'b1;
                  end else begin
                     cmd.res_load = 1'b1;
                  end
               end
               CMD_READ: begin
                  if (status.in_range) begin
                     cmd.rd_index = 1'b1;
                  end else begin
                     cmd.res_load = 1'b1;
                     cmd.res_code = RES_READ_EMPTY;
                     cmd.res_src = SRC_INDEX;
                  end
               end
               CMD_CLEAR: begin
                  cmd.clear = 1'b1;
                  cmd.res_load = 1'b1;
                  cmd.res_code = RES_CLEARED;
               end
               default: begin
                  cmd.res_load = 1'b1;
               end
            endcase
         end
         ST_SEARCH: begin
            if (status.hit) begin
               cmd.wr_bump = 1'b1;
               cmd.res_load = 1'b1;
               cmd.res_code = RES_INCREMENT;
               cmd.res_src = SRC_BUMPED;
            end else if (status.more) begin
               cmd.rd_scan = 1'b1;
            end else if (!status.rd_pending) begin
               cmd.res_load = 1'b1;
               if (!status.full) begin
                  cmd.wr_new = 1'b1;
                  cmd.res_code = RES_NEW;
                  cmd.res_src = SRC_NEW;
               end else begin
                  cmd.set_ovf = 1'b1;
                  cmd.res_code = RES_DROPPED;
               end
            end
         end
         ST_READ_WAIT: begin
            cmd.res_load = 1'b1;
            cmd.res_code = RES_READ_VALID;
            cmd.res_src = SRC_STORED;
         end
         ST_EMIT: begin
            cmd.emit = status.rsp_free;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

>>> design/hact_datapath.sv
// Entry memories, counters, scan pointer and response register of the hit table.
`default_nettype none

module hact_datapath #(
   parameter int TABLE_DEPTH   = hact_pkg::DEPTH_DEFAULT,
   parameter int ADDRESS_WIDTH = hact_pkg::ADDR_W_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire hact_pkg::req_word_type  req_word,
   input  wire hact_pkg::ctl_cmd_type   cmd,
   output hact_pkg::dp_status_type      status,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output hact_pkg::rsp_word_type       rsp_word
);
   import hact_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
   localparam int AW     = ADDRESS_WIDTH;

   // entry memories, reset value undefined
   logic [AW-1:0]      addr_mem_ff [TABLE_DEPTH];
   logic [COUNT_W-1:0] cnt_mem_ff  [TABLE_DEPTH];
   logic [AW-1:0]      addr_rd_ff;
   logic [COUNT_W-1:0] cnt_rd_ff;

   req_word_type       req_ff;
   logic [FILL_W-1:0]  fill_ff,  fill_in;
   logic               ovf_ff,   ovf_in;
   logic [COUNT_W-1:0] hits_ff,  hits_in;
   logic [FILL_W-1:0]  scan_ff,  scan_in;
   logic               rd_pending_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;

   res_code_type           res_code_ff, res_code_in;
   logic [IDX_PORT_W-1:0]  res_idx_ff,  res_idx_in;
   logic [ADDR_PORT_W-1:0] res_addr_ff, res_addr_in;
   logic [COUNT_W-1:0]     res_cnt_ff,  res_cnt_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff,  rsp_word_in;

   logic [WIDE_W-1:0]  ridx_wide, fill_wide, cmp_wide;
   logic [AW-1:0]      req_addr;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_idx;
   logic [COUNT_W-1:0] cnt_bumped;
   logic               hit;

   assign ridx_wide  = WIDE_W'(req_ff.read_index);
   assign fill_wide  = WIDE_W'(fill_ff);
   assign cmp_wide   = WIDE_W'(cmp_idx_ff);
   assign req_addr   = req_ff.hit_address[AW-1:0];
   assign rd_en      = cmd.rd_scan || cmd.rd_index;
   assign rd_idx     = cmd.rd_scan ? scan_ff[IDX_W-1:0] : ridx_wide[IDX_W-1:0];
   assign cnt_bumped = (cnt_rd_ff == '1) ? cnt_rd_ff : cnt_rd_ff + COUNT_W'(1);
   assign hit        = rd_pending_ff && (addr_rd_ff == req_addr);

   always_comb begin
      status.cmd          = req_ff.cmd;
      status.debug_status = req_ff.debug_status;
      status.in_range     = ridx_wide < fill_wide;
      status.more         = scan_ff < fill_ff;
      status.rd_pending   = rd_pending_ff;
      status.hit          = hit;
      status.full         = fill_ff == FILL_W'(TABLE_DEPTH);
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (cmd.wr_new) addr_mem_ff[fill_ff[IDX_W-1:0]] <= req_addr;
      if (rd_en) addr_rd_ff <= addr_mem_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_new) begin
         cnt_mem_ff[fill_ff[IDX_W-1:0]] <= COUNT_W'(1);
      end else if (cmd.wr_bump) begin
         cnt_mem_ff[cmp_idx_ff] <= cnt_bumped;
      end
      if (rd_en) cnt_rd_ff <= cnt_mem_ff[rd_idx];
   end

   // table bookkeeping; a clear zeroes fill count, overflow flag and hit total, memories stay
   always_comb begin
      fill_in = fill_ff;
      ovf_in  = ovf_ff;
      hits_in = hits_ff;
      scan_in = scan_ff;
      if (cmd.clear) begin
         fill_in = '0;
         ovf_in  = 1'b0;
         hits_in = '0;
      end
      if (cmd.wr_new) fill_in = fill_ff + FILL_W'(1);
      if (cmd.set_ovf) ovf_in = 1'b1;
      if (cmd.hit_bump && hits_ff != '1) hits_in = hits_ff + COUNT_W'(1);
      if (cmd.scan_start) begin
         scan_in = '0;
      end else if (cmd.rd_scan) begin
         scan_in = scan_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         ovf_ff        <= 1'b0;
         hits_ff       <= '0;
         scan_ff       <= '0;
         rd_pending_ff <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         ovf_ff        <= ovf_in;
         hits_ff       <= hits_in;
         scan_ff       <= scan_in;
         rd_pending_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) req_ff <= req_word;
      if (rd_en) cmp_idx_ff <= rd_idx;
   end

   // pending result fields
   always_comb begin
      res_code_in = cmd.res_code;
      res_idx_in  = '0;
      res_addr_in = '0;
      res_cnt_in  = '0;
      case (cmd.res_src)
         SRC_INDEX: begin
            res_idx_in = req_ff.read_index;
         end
         SRC_STORED: begin
            res_idx_in  = cmp_wide[IDX_PORT_W-1:0];
            res_addr_in = ADDR_PORT_W'(addr_rd_ff);
            res_cnt_in  = cnt_rd_ff;
         end
         SRC_BUMPED: begin
            res_idx_in  = cmp_wide[IDX_PORT_W-1:0];
            res_addr_in = ADDR_PORT_W'(addr_rd_ff);
            res_cnt_in  = cnt_bumped;
         end
         SRC_NEW: begin
            res_idx_in  = fill_wide[IDX_PORT_W-1:0];
            res_addr_in = ADDR_PORT_W'(req_addr);
            res_cnt_in  = COUNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_code_ff <= res_code_in;
         res_idx_ff  <= res_idx_in;
         res_addr_ff <= res_addr_in;
         res_cnt_ff  <= res_cnt_in;
      end
   end

   // response register: flags and counts are final by the time of emit
   always_comb begin
      rsp_word_in.result_code   = res_code_ff;
      rsp_word_in.entry_index   = res_idx_ff;
      rsp_word_in.entry_address = res_addr_ff;
      rsp_word_in.entry_count   = res_cnt_ff;
      rsp_word_in.overflow_flag = ovf_ff;
      rsp_word_in.total_hits    = hits_ff;
      rsp_word_in.entries_used  = fill_wide[USED_W-1:0];
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_new |=> fill_ff == $past(fill_ff) + FILL_W'(1))
      else $error("fill count did not advance on insert");

   a_no_read_on_hit: assert property (@(posedge clock) disable iff (reset)
      hit |-> !rd_en)
      else $error("read issued while a match sits in the read register");

   a_pending_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_pending_ff |-> cmp_wide < fill_wide)
      else $error("compared entry lies beyond the filled range");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response word overwritten before it was taken");

endmodule

`default_nettype wire

>>> design/hit_address_count_table.sv
// Top level of the hit address count table: controller plus datapath.
// Ignore, clear and empty read answer straight from dispatch; a filled read waits for the
// registered memory read; a record scans the entries in order up to the first match.
// Next word is taken in the cycle after the response loads; the scan reads one entry
// per cycle through the single memory port, so a record grows with the fill count.
// Reset is synchronous and empties the table at once (fill count zeroed), no clearing pass.
`default_nettype none

module hit_address_count_table #(
   parameter int TABLE_DEPTH   = hact_pkg::DEPTH_DEFAULT,
   parameter int ADDRESS_WIDTH = hact_pkg::ADDR_W_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire hact_pkg::req_word_type  req_word,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output hact_pkg::rsp_word_type       rsp_word
);
   import hact_pkg::*;

   // command and status between sequencer and datapath
   ctl_cmd_type   cmd;
   dp_status_type status;

   // Sequencer: one word at a time, the response register lets the
   // next word in while the last response waits.
   hact_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: entries live in memories, valid means index below fill count
   // since entries fill strictly in order.
   hact_datapath #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .ADDRESS_WIDTH (ADDRESS_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
